### rtl/core/ffha_pkg.sv
package ffha_pkg;

    // table geometry
    localparam int MAX_PARTS = 64;
    localparam int IDX_W     = $clog2(MAX_PARTS);
    localparam int CNT_W     = $clog2(MAX_PARTS + 1);

    // register reset values
    localparam logic [15:0] HEAP_RST = 16'd4096;
    localparam logic [6:0]  META_RST = 7'd16;

    // request kinds
    localparam logic [1:0] FN_ALLOC  = 2'd0;
    localparam logic [1:0] FN_FREE   = 2'd1;
    localparam logic [1:0] FN_REINIT = 2'd2;

    // result codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOFIT   = 2'd1;
    localparam logic [1:0] ST_NOMATCH = 2'd2;

    // register indexes
    localparam logic RG_HEAP = 1'b0;
    localparam logic RG_META = 1'b1;

    // compare unit modes
    localparam logic [1:0] CM_FIT   = 2'd0;
    localparam logic [1:0] CM_SPLIT = 2'd1;
    localparam logic [1:0] CM_ADDR  = 2'd2;

    // one partition table entry
    typedef struct packed {
        logic        free;
        logic [15:0] size;
        logic [15:0] offset;
    } t_part;

    // operands for the shared compare unit
    typedef struct packed {
        logic [1:0]  mode;
        t_part       ent;
        logic [16:0] rsz;
        logic [6:0]  meta;
        logic [15:0] faddr;
    } t_cmp_req;

endpackage

### rtl/core/ffha_cmp.sv
module ffha_cmp (
    input  ffha_pkg::t_cmp_req i_req,
    output logic               o_hit
);
    import ffha_pkg::*;

    logic [17:0] split_need;
    logic [15:0] data_off;

    // derived operands for the split and address tests
    assign split_need = {1'b0, i_req.rsz} + {11'b0, i_req.meta} + 18'd4;
    assign data_off   = i_req.ent.offset + {9'b0, i_req.meta};

    // one test per cycle, picked by the sequencer
    always_comb begin
        case (i_req.mode)
            CM_FIT:   o_hit = i_req.ent.free && ({1'b0, i_req.ent.size} >= i_req.rsz);
            CM_SPLIT: o_hit = {2'b0, i_req.ent.size} >= split_need;
            CM_ADDR:  o_hit = data_off == i_req.faddr;
            default:  o_hit = 1'b0;
        endcase
    end

endmodule

### rtl/core/first_fit_heap_allocator.sv
// channel   dir  handshake              payload
// s (req)   in   i_s_tvalid/o_s_tready  tuser: func; tdata: req_size, free_addr
// m (res)   out  o_m_tvalid/i_m_tready  tuser: status; tdata: addr
// apb       in   psel/penable/pready    heap_size @0x0, meta_size @0x4
//
// free walks the table one entry per cycle from the partition table memory,
// checked by the shared compare unit. alloc adds a split decision and, when it
// splits, a shift of the entries behind the chosen one and a write of the new
// partition; the chosen entry is then written. reinit writes one entry, an
// unused func goes straight to done. after reset S_INIT writes the first entry.
// a result waits in the output register; a second one stalls the sequencer there.
module first_fit_heap_allocator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // [15:0] req_size, [31:16] free_addr
    input  logic [1:0]  i_s_tuser,   // [1:0] func
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,   // [15:0] addr
    output logic [1:0]  o_m_tuser,   // [1:0] status
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import ffha_pkg::*;

    localparam logic [3:0] S_INIT   = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_REINIT = 4'd2;
    localparam logic [3:0] S_SCAN   = 4'd3;
    localparam logic [3:0] S_DECIDE = 4'd4;
    localparam logic [3:0] S_SHIFT  = 4'd5;
    localparam logic [3:0] S_SPLIT  = 4'd6;
    localparam logic [3:0] S_HEAD   = 4'd7;
    localparam logic [3:0] S_DONE   = 4'd8;

    logic [3:0]       r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [IDX_W-1:0] r_j, n_j;
    logic [IDX_W-1:0] r_found, n_found;
    t_part            r_ent, n_ent;
    logic [1:0]       r_func, n_func;
    logic [16:0]      r_rsz, n_rsz;
    logic [15:0]      r_faddr, n_faddr;
    logic [15:0]      r_newsize, n_newsize;
    logic [1:0]       r_status, n_status;
    logic [15:0]      r_addr, n_addr;
    logic             r_m_valid, n_m_valid;
    logic [1:0]       r_m_status, n_m_status;
    logic [15:0]      r_m_addr, n_m_addr;
    logic [15:0]      r_heap;
    logic [6:0]       r_meta;

    t_part            r_mem [MAX_PARTS];
    t_part            r_rd_data;
    logic             mem_we;
    logic [IDX_W-1:0] mem_wa;
    t_part            mem_wd;
    logic [IDX_W-1:0] rd_addr;

    t_cmp_req         cmp_req;
    logic             cmp_hit;
    logic             s_acc;
    logic             cfg_wr;
    logic [15:0]      meta16;
    logic [16:0]      req_up;
    logic             scan_last;

    assign meta16     = {9'b0, r_meta};
    assign o_s_tready = (r_state == S_IDLE);
    assign s_acc      = i_s_tvalid && o_s_tready;
    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_addr;
    assign o_m_tuser  = r_m_status;
    assign scan_last  = (CNT_W'(r_idx) + CNT_W'(1)) == r_count;

    // request size rounded up to a word (zero stays zero; the sequencer maps it to one word)
    assign req_up = ({1'b0, i_s_tdata[15:0]} + 17'd3) & ~17'd3;

    // configuration registers
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heap <= HEAP_RST;
            r_meta <= META_RST;
        end else if (cfg_wr) begin
            case (paddr[2])
                RG_HEAP: r_heap <= pwdata[15:0];
                RG_META: r_meta <= pwdata[6:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            RG_HEAP: prdata = {16'b0, r_heap};
            RG_META: prdata = {25'b0, r_meta};
            default: prdata = '0;
        endcase
    end

    // partition table memory
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    // shared compare unit
    ffha_cmp u_cmp (
        .i_req (cmp_req),
        .o_hit (cmp_hit)
    );

    // sequencer
    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_idx      = r_idx;
        n_j        = r_j;
        n_found    = r_found;
        n_ent      = r_ent;
        n_func     = r_func;
        n_rsz      = r_rsz;
        n_faddr    = r_faddr;
        n_newsize  = r_newsize;
        n_status   = r_status;
        n_addr     = r_addr;
        n_m_valid  = r_m_valid;
        n_m_status = r_m_status;
        n_m_addr   = r_m_addr;
        mem_we     = 1'b0;
        mem_wa     = '0;
        mem_wd     = '0;
        rd_addr    = '0;
        cmp_req.mode  = CM_FIT;
        cmp_req.ent   = r_rd_data;
        cmp_req.rsz   = r_rsz;
        cmp_req.meta  = r_meta;
        cmp_req.faddr = r_faddr;

        // output register drains independently
        if (i_m_tready) begin
            n_m_valid = 1'b0;
        end

        case (r_state)
            // initial partition from the reset register values
            S_INIT: begin
                mem_we  = 1'b1;
                mem_wd  = '{free: 1'b1, size: HEAP_RST - {9'b0, META_RST}, offset: 16'd0};
                n_count = CNT_W'(1);
                n_state = S_IDLE;
            end
            S_IDLE: begin
                if (s_acc) begin
                    n_func   = i_s_tuser;
                    n_rsz    = (i_s_tdata[15:0] == 16'd0) ? 17'd4 : req_up;
                    n_faddr  = i_s_tdata[31:16];
                    n_status = ST_OK;
                    n_addr   = 16'd0;
                    case (i_s_tuser)
                        FN_ALLOC, FN_FREE: begin
                            n_idx   = '0;
                            n_state = S_SCAN;
                        end
                        FN_REINIT: n_state = S_REINIT;
                        default:   n_state = S_DONE;
                    endcase
                end
            end
            S_REINIT: begin
                mem_we  = 1'b1;
                mem_wd  = '{free: 1'b1,
                            size: (r_heap > meta16) ? (r_heap - meta16) : 16'd0,
                            offset: 16'd0};
                n_count = CNT_W'(1);
                n_state = S_DONE;
            end
            // walk the table, one entry per cycle
            S_SCAN: begin
                cmp_req.mode = (r_func == FN_FREE) ? CM_ADDR : CM_FIT;
                rd_addr      = r_idx + IDX_W'(1);
                if (cmp_hit) begin
                    if (r_func == FN_FREE) begin
                        mem_we  = 1'b1;
                        mem_wa  = r_idx;
                        mem_wd  = r_rd_data;
                        mem_wd.free = 1'b1;
                        n_state = S_DONE;
                    end else begin
                        n_ent   = r_rd_data;
                        n_found = r_idx;
                        n_state = S_DECIDE;
                    end
                end else if (scan_last) begin
                    n_status = (r_func == FN_FREE) ? ST_NOMATCH : ST_NOFIT;
                    n_state  = S_DONE;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            // split only if the rest holds a header and a word, and room is left
            S_DECIDE: begin
                cmp_req.mode = CM_SPLIT;
                cmp_req.ent  = r_ent;
                if (cmp_hit && (r_count < CNT_W'(MAX_PARTS))) begin
                    n_newsize = r_rsz[15:0];
                    if (r_count > (CNT_W'(r_found) + CNT_W'(1))) begin
                        rd_addr = IDX_W'(r_count - CNT_W'(1));
                        n_j     = IDX_W'(r_count);
                        n_state = S_SHIFT;
                    end else begin
                        n_state = S_SPLIT;
                    end
                end else begin
                    n_newsize = r_ent.size;
                    n_state   = S_HEAD;
                end
            end
            // move entries behind the chosen one up by one slot
            S_SHIFT: begin
                mem_we = 1'b1;
                mem_wa = r_j;
                mem_wd = r_rd_data;
                if ((r_j - IDX_W'(1)) == (r_found + IDX_W'(1))) begin
                    n_state = S_SPLIT;
                end else begin
                    rd_addr = r_j - IDX_W'(2);
                    n_j     = r_j - IDX_W'(1);
                end
            end
            // new free partition holding the remainder
            S_SPLIT: begin
                mem_we  = 1'b1;
                mem_wa  = r_found + IDX_W'(1);
                mem_wd  = '{free: 1'b1,
                            size: r_ent.size - meta16 - r_rsz[15:0],
                            offset: r_ent.offset + meta16 + r_rsz[15:0]};
                n_count = r_count + CNT_W'(1);
                n_state = S_HEAD;
            end
            // mark the chosen partition occupied
            S_HEAD: begin
                mem_we  = 1'b1;
                mem_wa  = r_found;
                mem_wd  = '{free: 1'b0, size: r_newsize, offset: r_ent.offset};
                n_addr  = r_ent.offset + meta16;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_m_valid || i_m_tready) begin
                    n_m_valid  = 1'b1;
                    n_m_status = r_status;
                    n_m_addr   = r_addr;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_INIT;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_INIT;
            r_count   <= CNT_W'(1);
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_m_valid <= n_m_valid;
        end
    end

    // payload and scan registers
    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_j        <= n_j;
        r_found    <= n_found;
        r_ent      <= n_ent;
        r_func     <= n_func;
        r_rsz      <= n_rsz;
        r_faddr    <= n_faddr;
        r_newsize  <= n_newsize;
        r_status   <= n_status;
        r_addr     <= n_addr;
        r_m_status <= n_m_status;
        r_m_addr   <= n_m_addr;
    end

    // table fill stays within bounds
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != '0) && (r_count <= CNT_W'(MAX_PARTS)))
        else $error("partition count out of range");

    // shift never reaches the slot of the new partition
    a_shift_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFT) |-> (CNT_W'(r_j) > (CNT_W'(r_found) + CNT_W'(1))))
        else $error("shift index below split slot");

    // scanning never changes the fill
    a_scan_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |=> (r_count == $past(r_count)))
        else $error("partition count changed during scan");

endmodule

### bench/tb.sv
`timescale 1ns / 1ps

module tb;
    import ffha_pkg::*;

    // unused request kind, must answer done with no change
    localparam logic [1:0] FN_UNUSED = 2'd3;
    localparam logic [2:0] ADDR_HEAP = {RG_HEAP, 2'b00};
    localparam logic [2:0] ADDR_META = {RG_META, 2'b00};
    localparam int DRAIN_CYCLES   = 2 * MAX_PARTS + 24;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int PRESSURE_HOLD  = 400;
    localparam int POOL_DEPTH     = 64;

    typedef struct {
        logic [1:0]  fn;
        logic [15:0] req_size;
        logic [15:0] free_addr;
    } t_heap_req;

    typedef struct {
        logic [1:0]  status;
        logic [15:0] addr;
    } t_heap_res;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [31:0] i_s_tdata = '0;
    logic [1:0]  i_s_tuser = '0;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [15:0] o_m_tdata;
    logic [1:0]  o_m_tuser;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // heap shadow: partition table, live count and registers
    t_part       heap_parts [MAX_PARTS];
    int          part_num;
    logic [15:0] cfg_heap;
    logic [6:0]  cfg_meta;

    t_heap_req   pending_reqs [$];
    t_heap_res   expected_results [$];
    logic [15:0] granted_addrs [$];

    int  reqs_issued = 0;
    int  reqs_taken = 0;
    int  results_seen = 0;
    int  mismatches = 0;
    int  idle_cycles = 0;
    int  n_alloc_ok = 0;
    int  n_nofit = 0;
    int  n_nomatch = 0;
    int  n_full_table = 0;
    int  peak_parts = 0;
    bit  req_fire = 1'b0;
    bit  tx_stall_on = 1'b0;
    bit  rx_stall_on = 1'b0;
    int  tx_gap = 0;
    int  rx_gap = 0;
    int  rx_hold = 0;
    int  pressure_seq = 0;
    int  pressure_seen = 0;

    first_fit_heap_allocator uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always #5 i_clk = ~i_clk;

    // idle length: mostly none, some short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 50);
    endfunction

    // one free partition covering the heap
    function automatic void heap_reset_layout();
        for (int i = 0; i < MAX_PARTS; i++)
            heap_parts[i] = '0;
        heap_parts[0].free = 1'b1;
        heap_parts[0].size = (cfg_heap > 16'(cfg_meta)) ? cfg_heap - 16'(cfg_meta) : 16'd0;
        part_num = 1;
    endfunction

    // apply one request to the shadow heap and queue its result
    function automatic void heap_apply_request(t_heap_req rq);
        t_heap_res res;
        int        rsz;
        int        hit;
        res.status = ST_OK;
        res.addr   = '0;
        hit        = -1;
        case (rq.fn)
            FN_ALLOC: begin
                rsz = (rq.req_size == 0) ? 4 : (((int'(rq.req_size) - 1) >> 2) << 2) + 4;
                for (int i = 0; i < part_num && hit < 0; i++)
                    if (heap_parts[i].free && int'(heap_parts[i].size) >= rsz)
                        hit = i;
                if (hit < 0) begin
                    res.status = ST_NOFIT;
                    n_nofit++;
                end else begin
                    // split off the tail when it can hold a header and one word
                    if (int'(heap_parts[hit].size) >= rsz + int'(cfg_meta) + 4) begin
                        if (part_num < MAX_PARTS) begin
                            for (int j = part_num; j > hit + 1; j--)
                                heap_parts[j] = heap_parts[j - 1];
                            heap_parts[hit + 1].offset =
                                16'(int'(heap_parts[hit].offset) + int'(cfg_meta) + rsz);
                            heap_parts[hit + 1].size =
                                16'(int'(heap_parts[hit].size) - int'(cfg_meta) - rsz);
                            heap_parts[hit + 1].free = 1'b1;
                            heap_parts[hit].size = 16'(rsz);
                            part_num++;
                        end else begin
                            n_full_table++;
                        end
                    end
                    heap_parts[hit].free = 1'b0;
                    res.addr = 16'(int'(heap_parts[hit].offset) + int'(cfg_meta));
                    n_alloc_ok++;
                    granted_addrs.push_back(res.addr);
                    if (granted_addrs.size() > POOL_DEPTH)
                        void'(granted_addrs.pop_front());
                end
            end
            FN_FREE: begin
                for (int i = 0; i < part_num && hit < 0; i++)
                    if (16'(int'(heap_parts[i].offset) + int'(cfg_meta)) == rq.free_addr) begin
                        heap_parts[i].free = 1'b1;
                        hit = i;
                    end
                if (hit < 0) begin
                    res.status = ST_NOMATCH;
                    n_nomatch++;
                end
            end
            FN_REINIT: heap_reset_layout();
            default: ;
        endcase
        if (part_num > peak_parts)
            peak_parts = part_num;
        expected_results.push_back(res);
    endfunction

    function automatic void note_mismatch(string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endfunction

    // request driver
    always @(negedge i_clk) begin
        t_heap_req rq;
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else if (i_s_tvalid && !req_fire) begin
            // hold the offered request
        end else if (tx_gap > 0) begin
            tx_gap--;
            i_s_tvalid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
            rq = pending_reqs.pop_front();
            i_s_tvalid <= 1'b1;
            i_s_tdata  <= {rq.free_addr, rq.req_size};
            i_s_tuser  <= rq.fn;
            if (tx_stall_on)
                tx_gap = pick_gap();
        end else begin
            i_s_tvalid <= 1'b0;
        end
    end

    // result receiver, with one long hold-off on demand
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else if (pressure_seq != pressure_seen) begin
            pressure_seen = pressure_seq;
            rx_hold = PRESSURE_HOLD;
            i_m_tready <= 1'b0;
        end else if (rx_hold > 0) begin
            rx_hold--;
            i_m_tready <= 1'b0;
        end else if (rx_gap > 0) begin
            rx_gap--;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
            if (rx_stall_on)
                rx_gap = pick_gap();
        end
    end

    // monitor: register writes, requests, results and watchdog
    always @(posedge i_clk) begin
        t_heap_res want;
        t_heap_req rq;
        req_fire <= i_s_tvalid && o_s_tready;
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready) begin
                results_seen++;
                if (expected_results.size() == 0) begin
                    note_mismatch($sformatf("result status=%0d addr=%0d with none expected",
                                            o_m_tuser, o_m_tdata));
                end else begin
                    want = expected_results.pop_front();
                    if (o_m_tuser !== want.status)
                        note_mismatch($sformatf("status expected %0d got %0d",
                                                want.status, o_m_tuser));
                    if (o_m_tdata !== want.addr)
                        note_mismatch($sformatf("addr expected %0d got %0d",
                                                want.addr, o_m_tdata));
                end
            end
            if (i_s_tvalid && o_s_tready) begin
                rq.fn        = i_s_tuser;
                rq.req_size  = i_s_tdata[15:0];
                rq.free_addr = i_s_tdata[31:16];
                heap_apply_request(rq);
                reqs_taken++;
            end
            if (psel && penable && pwrite && pready) begin
                if (paddr == ADDR_HEAP)
                    cfg_heap = pwdata[15:0];
                else if (paddr == ADDR_META)
                    cfg_meta = pwdata[6:0];
            end
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) ||
                (psel && penable && pready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no progress for %0d cycles", idle_cycles);
                $display("Mismatches found");
                $finish;
            end
        end
    end

    task automatic apb_write(input logic [2:0] a, input logic [31:0] d);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= a;
        pwdata  <= d;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic queue_req(input logic [1:0] fn, input logic [15:0] rsz,
                             input logic [15:0] fa);
        t_heap_req rq;
        rq.fn        = fn;
        rq.req_size  = rsz;
        rq.free_addr = fa;
        while (pending_reqs.size() >= 2)
            @(negedge i_clk);
        pending_reqs.push_back(rq);
        reqs_issued++;
    endtask

    // wait until every request is answered, then let the block settle
    task automatic drain();
        while (reqs_taken != reqs_issued || expected_results.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // free address: mostly a granted one, else near-miss or random
    function automatic logic [15:0] pick_free_addr();
        int r;
        r = $urandom_range(0, 99);
        if (granted_addrs.size() == 0 || r >= 85)
            return 16'($urandom);
        if (r >= 70)
            return granted_addrs[$urandom_range(0, granted_addrs.size() - 1)]
                   + 16'($urandom_range(1, 8));
        return granted_addrs[$urandom_range(0, granted_addrs.size() - 1)];
    endfunction

    function automatic logic [15:0] pick_req_size();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 16'($urandom_range(0, 64));
        if (r < 80)
            return 16'($urandom_range(0, cfg_heap / 4));
        if (r < 95)
            return 16'($urandom_range(0, cfg_heap));
        return 16'($urandom);
    endfunction

    task automatic run_random_phase(input int n_items, input bit start_clean);
        int r;
        if (start_clean)
            queue_req(FN_REINIT, 16'($urandom), 16'($urandom));
        for (int k = 0; k < n_items; k++) begin
            r = $urandom_range(0, 99);
            if (r < 55)
                queue_req(FN_ALLOC, pick_req_size(), 16'($urandom));
            else if (r < 90)
                queue_req(FN_FREE, 16'($urandom), pick_free_addr());
            else if (r < 96)
                queue_req(FN_REINIT, 16'($urandom), 16'($urandom));
            else
                queue_req(FN_UNUSED, 16'($urandom), 16'($urandom));
        end
    endtask

    initial begin
        int r;
        cfg_heap = HEAP_RST;
        cfg_meta = META_RST;
        heap_reset_layout();
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        rx_stall_on = 1'b1;

        // directed: rounding, huge requests, double and unmatched free, unused kind
        queue_req(FN_ALLOC, 16'd0, 16'($urandom));
        queue_req(FN_ALLOC, 16'd1, 16'($urandom));
        queue_req(FN_ALLOC, 16'd65535, 16'($urandom));
        queue_req(FN_ALLOC, 16'd65533, 16'($urandom));
        queue_req(FN_ALLOC, 16'd65532, 16'($urandom));
        queue_req(FN_FREE, 16'($urandom), 16'd16);
        queue_req(FN_FREE, 16'($urandom), 16'd16);
        queue_req(FN_FREE, 16'($urandom), 16'd17);
        queue_req(FN_FREE, 16'($urandom), 16'd65535);
        queue_req(FN_UNUSED, 16'($urandom), 16'($urandom));
        queue_req(FN_ALLOC, 16'd3, 16'($urandom));
        queue_req(FN_REINIT, 16'($urandom), 16'($urandom));
        queue_req(FN_ALLOC, 16'd4080, 16'($urandom));
        queue_req(FN_ALLOC, 16'd0, 16'($urandom));
        queue_req(FN_FREE, 16'($urandom), 16'd16);
        drain();

        // largest heap, smallest header: whole-heap requests that round past the heap
        apb_write(ADDR_HEAP, 32'd65535);
        apb_write(ADDR_META, 32'd4);
        queue_req(FN_REINIT, 16'($urandom), 16'($urandom));
        queue_req(FN_ALLOC, 16'd65531, 16'($urandom));
        queue_req(FN_ALLOC, 16'd0, 16'($urandom));
        queue_req(FN_FREE, 16'($urandom), 16'd4);
        queue_req(FN_ALLOC, 16'd65532, 16'($urandom));
        drain();

        // heap no larger than one header: zero-size partition
        apb_write(ADDR_HEAP, 32'd64);
        apb_write(ADDR_META, 32'd64);
        queue_req(FN_REINIT, 16'($urandom), 16'($urandom));
        queue_req(FN_ALLOC, 16'd0, 16'($urandom));
        queue_req(FN_FREE, 16'($urandom), 16'd64);
        drain();

        // fill the table with tiny blocks while the receiver holds off
        apb_write(ADDR_HEAP, 32'd4096);
        apb_write(ADDR_META, 32'd4);
        tx_stall_on = 1'b0;
        queue_req(FN_REINIT, 16'($urandom), 16'($urandom));
        for (int k = 0; k < 75; k++) begin
            if (k == 8)
                pressure_seq++;
            queue_req(FN_ALLOC, 16'($urandom_range(0, 8)), 16'($urandom));
        end
        for (int k = 0; k < 20; k++) begin
            if ($urandom_range(0, 1))
                queue_req(FN_FREE, 16'($urandom), pick_free_addr());
            else
                queue_req(FN_ALLOC, 16'($urandom_range(0, 12)), 16'($urandom));
        end
        drain();

        // random phases over a spread of register settings
        for (int p = 0; p < 6; p++) begin
            r = $urandom_range(0, 9);
            if (r == 0)
                apb_write(ADDR_HEAP, 32'd64);
            else if (r == 1)
                apb_write(ADDR_HEAP, 32'd65535);
            else if (r < 6)
                apb_write(ADDR_HEAP, $urandom_range(64, 1024));
            else if (r < 9)
                apb_write(ADDR_HEAP, $urandom_range(1025, 8192));
            r = $urandom_range(0, 9);
            if (r == 0)
                apb_write(ADDR_META, 32'd4);
            else if (r == 1)
                apb_write(ADDR_META, 32'd64);
            else
                apb_write(ADDR_META, $urandom_range(4, 64));
            tx_stall_on = (p != 0) && $urandom_range(0, 3) != 0;
            rx_stall_on = (p != 0) && $urandom_range(0, 3) != 0;
            run_random_phase(50, $urandom_range(0, 3) != 0);
            drain();
        end

        $display("requests %0d, results %0d: %0d allocations, %0d no-fit, %0d unmatched frees",
                 reqs_taken, results_seen, n_alloc_ok, n_nofit, n_nomatch);
        $display("peak partitions %0d of %0d, splits skipped on a full table %0d",
                 peak_parts, MAX_PARTS, n_full_table);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

### filelist.f
rtl/core/ffha_pkg.sv
rtl/core/ffha_cmp.sv
rtl/core/first_fit_heap_allocator.sv
bench/tb.sv
